@@ design/sci_pkg.sv @@
package sci_pkg;

   // Circle register map
   typedef enum logic [1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   // Perimeter crossing counts
   localparam logic [1:0] CNT_NONE = 2'd0;
   localparam logic [1:0] CNT_ONE  = 2'd1;
   localparam logic [1:0] CNT_TWO  = 2'd2;

   // Sign and ordering tests on the squared terms
   typedef struct packed {
      logic box;    // both endpoints beyond one side of the bounding square
      logic zl;     // zero length segment
      logic bnn;    // b >= 0
      logic bpos;   // b > 0
      logic nb_ge;  // -b >= len2
      logic nb_le;  // -b <= len2
      logic nb_gt;  // -b > len2
      logic q1n;    // start strictly inside
      logic q2n;    // end strictly inside
      logic q1z;    // start on perimeter
      logic q2z;    // end on perimeter
      logic q1np;   // start inside or on perimeter
      logic q2np;   // end inside or on perimeter
      logic c_ok;   // nearer endpoint not outside
   } geo_flags_type;

   // Per-request answers travelling with the length computation
   typedef struct packed {
      logic       loose;
      logic       strict;
      logic [1:0] count;
   } result_flags_type;

endpackage

@@ design/segment_circle_intersect.sv @@
// Pipeline: setup, bit-per-stage root of RT + 1 bits with RT = min(2*COORD_BITS + 4, 62),
//    squaring, then bit-per-stage ratio root.
// Throughput: one request per cycle; a stalled response holds the whole pipeline in place.
// Reset clears all stage valid bits and sets center and radius to zero.
module segment_circle_intersect #(
   parameter int COORD_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [COORD_BITS-1:0]      req_start_x,
   input  logic signed [COORD_BITS-1:0]      req_start_y,
   input  logic signed [COORD_BITS-1:0]      req_end_x,
   input  logic signed [COORD_BITS-1:0]      req_end_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit_loose,
   output logic                              rsp_hit_strict,
   output logic [1:0]                        rsp_crossing_count,
   output logic [COORD_BITS:0]               rsp_inside_length,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  sci_pkg::csr_index_type            csr_index,
   input  logic [COORD_BITS-1:0]             csr_data
);
   import sci_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int DB = CB + 1;                 // coordinate differences
   localparam int EB = CB + 2;                 // bounding square limits
   localparam int SB = 2 * CB + 4;             // squared scalars
   localparam int HB = SB / 2;                 // multiplier slice
   localparam int WB = 2 * SB;                 // wide products
   localparam int RT = (2 * CB + 4 < 62) ? 2 * CB + 4 : 62;
   localparam int RN = RT + 1;                 // root bits and root stages
   localparam int MU = ((RN > SB) ? RN : SB) + 1;
   localparam int MH = (MU + 1) / 2;
   localparam int KB = CB + 1;                 // length bits and ratio stages
   localparam int AB = KB + SB;
   localparam int T0 = (2 * RT + 4 > WB) ? 2 * RT + 4 : WB;
   localparam int TW = ((T0 > 4 * MH) ? T0 : 4 * MH) + 2;

   typedef struct packed {
      geo_flags_type           fl;
      logic signed [SB-1:0]    p;
      logic [SB-1:0]           len2;
   } mid_type;

   typedef struct packed {
      result_flags_type        o;
      logic                    use_root;
      logic [TW-1:0]           y0;
      logic [SB-1:0]           l;
      logic signed [SB-1:0]    p;
   } carry_type;

   logic adv;

   // Circle registers
   logic signed [CB-1:0] center_x_ff, center_y_ff;
   logic [CB-2:0]        radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_data;
            CSR_CENTER_Y: center_y_ff <= csr_data;
            CSR_RADIUS:   radius_ff   <= csr_data[CB-2:0];
            default: ;
         endcase
      end
   end

   // Stage 1: offsets and bounding square reject
   logic                 v1_ff;
   logic signed [DB-1:0] fx1_ff, fy1_ff, gx1_ff, gy1_ff, dx1_ff, dy1_ff;
   logic signed [DB-1:0] fx1_in, fy1_in, gx1_in, gy1_in, dx1_in, dy1_in;
   logic [CB-2:0]        r1_ff;
   logic                 box1_ff, box1_in;

   always_comb begin
      logic signed [EB-1:0] cxw, cyw, rw, hx, lx, hy, ly, x1w, x2w, y1w, y2w;
      cxw = EB'(center_x_ff);
      cyw = EB'(center_y_ff);
      rw  = EB'(signed'({1'b0, radius_ff}));
      hx  = cxw + rw;
      lx  = cxw - rw;
      hy  = cyw + rw;
      ly  = cyw - rw;
      x1w = EB'(req_start_x);
      x2w = EB'(req_end_x);
      y1w = EB'(req_start_y);
      y2w = EB'(req_end_y);
      fx1_in = DB'(req_start_x) - DB'(center_x_ff);
      fy1_in = DB'(req_start_y) - DB'(center_y_ff);
      gx1_in = DB'(req_end_x) - DB'(center_x_ff);
      gy1_in = DB'(req_end_y) - DB'(center_y_ff);
      dx1_in = DB'(req_end_x) - DB'(req_start_x);
      dy1_in = DB'(req_end_y) - DB'(req_start_y);
      box1_in = (x1w > hx && x2w > hx) || (x1w < lx && x2w < lx) ||
                (y1w > hy && y2w > hy) || (y1w < ly && y2w < ly);
   end

   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fx1_ff  <= fx1_in;
         fy1_ff  <= fy1_in;
         gx1_ff  <= gx1_in;
         gy1_ff  <= gy1_in;
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         r1_ff   <= radius_ff;
         box1_ff <= box1_in;
      end
   end

   // Stage 2: coordinate products
   logic                   v2_ff, box2_ff;
   logic signed [2*DB-1:0] fxx2_ff, fyy2_ff, gxx2_ff, gyy2_ff, dxx2_ff, dyy2_ff;
   logic signed [2*DB-1:0] fdx2_ff, fdy2_ff, fxdy2_ff, fydx2_ff, gdx2_ff, gdy2_ff;
   logic signed [2*DB-1:0] fxx2_in, fyy2_in, gxx2_in, gyy2_in, dxx2_in, dyy2_in;
   logic signed [2*DB-1:0] fdx2_in, fdy2_in, fxdy2_in, fydx2_in, gdx2_in, gdy2_in;
   logic [2*CB-3:0]        rr2_ff, rr2_in;

   always_comb begin
      fxx2_in  = (2*DB)'(fx1_ff) * (2*DB)'(fx1_ff);
      fyy2_in  = (2*DB)'(fy1_ff) * (2*DB)'(fy1_ff);
      gxx2_in  = (2*DB)'(gx1_ff) * (2*DB)'(gx1_ff);
      gyy2_in  = (2*DB)'(gy1_ff) * (2*DB)'(gy1_ff);
      dxx2_in  = (2*DB)'(dx1_ff) * (2*DB)'(dx1_ff);
      dyy2_in  = (2*DB)'(dy1_ff) * (2*DB)'(dy1_ff);
      fdx2_in  = (2*DB)'(fx1_ff) * (2*DB)'(dx1_ff);
      fdy2_in  = (2*DB)'(fy1_ff) * (2*DB)'(dy1_ff);
      fxdy2_in = (2*DB)'(fx1_ff) * (2*DB)'(dy1_ff);
      fydx2_in = (2*DB)'(fy1_ff) * (2*DB)'(dx1_ff);
      gdx2_in  = (2*DB)'(gx1_ff) * (2*DB)'(dx1_ff);
      gdy2_in  = (2*DB)'(gy1_ff) * (2*DB)'(dy1_ff);
      rr2_in   = (2*CB-2)'(r1_ff) * (2*CB-2)'(r1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fxx2_ff  <= fxx2_in;
         fyy2_ff  <= fyy2_in;
         gxx2_ff  <= gxx2_in;
         gyy2_ff  <= gyy2_in;
         dxx2_ff  <= dxx2_in;
         dyy2_ff  <= dyy2_in;
         fdx2_ff  <= fdx2_in;
         fdy2_ff  <= fdy2_in;
         fxdy2_ff <= fxdy2_in;
         fydx2_ff <= fydx2_in;
         gdx2_ff  <= gdx2_in;
         gdy2_ff  <= gdy2_in;
         rr2_ff   <= rr2_in;
         box2_ff  <= box1_ff;
      end
   end

   // Stage 3: distances, length, dot and cross products
   logic                 v3_ff, box3_ff;
   logic signed [SB-1:0] d13_ff, d23_ff, len23_ff, b3_ff, cr3_ff, pg3_ff, q13_ff, q23_ff;
   logic signed [SB-1:0] r23_ff;
   logic signed [SB-1:0] d13_in, d23_in, len23_in, b3_in, cr3_in, pg3_in, q13_in, q23_in;
   logic signed [SB-1:0] r23_in;

   always_comb begin
      r23_in   = signed'(SB'(rr2_ff));
      d13_in   = SB'(fxx2_ff) + SB'(fyy2_ff);
      d23_in   = SB'(gxx2_ff) + SB'(gyy2_ff);
      len23_in = SB'(dxx2_ff) + SB'(dyy2_ff);
      b3_in    = SB'(fdx2_ff) + SB'(fdy2_ff);
      cr3_in   = SB'(fxdy2_ff) - SB'(fydx2_ff);
      pg3_in   = SB'(gdx2_ff) + SB'(gdy2_ff);
      q13_in   = SB'(fxx2_ff) + SB'(fyy2_ff) - r23_in;
      q23_in   = SB'(gxx2_ff) + SB'(gyy2_ff) - r23_in;
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d13_ff   <= d13_in;
         d23_ff   <= d23_in;
         len23_ff <= len23_in;
         b3_ff    <= b3_in;
         cr3_ff   <= cr3_in;
         pg3_ff   <= pg3_in;
         q13_ff   <= q13_in;
         q23_ff   <= q23_in;
         r23_ff   <= r23_in;
         box3_ff  <= box2_ff;
      end
   end

   // Stage 4: sign tests, nearer endpoint, magnitudes
   logic          v4_ff;
   mid_type       mid4_ff, mid4_in;
   logic [SB-1:0] r24_ff, magx4_ff, magp4_ff, cu4_ff;
   logic [SB-1:0] r24_in, magx4_in, magp4_in, cu4_in;

   always_comb begin
      logic signed [SB-1:0] nb, c;
      logic                 sel_f;
      nb    = -b3_ff;
      sel_f = d13_ff < d23_ff;
      c     = sel_f ? -q13_ff : -q23_ff;
      mid4_in.fl.box   = box3_ff;
      mid4_in.fl.zl    = len23_ff == '0;
      mid4_in.fl.bnn   = b3_ff >= 0;
      mid4_in.fl.bpos  = b3_ff > 0;
      mid4_in.fl.nb_ge = nb >= len23_ff;
      mid4_in.fl.nb_le = nb <= len23_ff;
      mid4_in.fl.nb_gt = nb > len23_ff;
      mid4_in.fl.q1n   = q13_ff < 0;
      mid4_in.fl.q2n   = q23_ff < 0;
      mid4_in.fl.q1z   = q13_ff == '0;
      mid4_in.fl.q2z   = q23_ff == '0;
      mid4_in.fl.q1np  = q13_ff <= 0;
      mid4_in.fl.q2np  = q23_ff <= 0;
      mid4_in.fl.c_ok  = c >= 0;
      mid4_in.p        = sel_f ? b3_ff : -pg3_ff;
      mid4_in.len2     = SB'(len23_ff);
      r24_in   = SB'(r23_ff);
      magx4_in = cr3_ff[SB-1] ? SB'(-cr3_ff) : SB'(cr3_ff);
      magp4_in = mid4_in.p[SB-1] ? SB'(-mid4_in.p) : SB'(mid4_in.p);
      cu4_in   = (c >= 0) ? SB'(c) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid4_ff  <= mid4_in;
         r24_ff   <= r24_in;
         magx4_ff <= magx4_in;
         magp4_ff <= magp4_in;
         cu4_ff   <= cu4_in;
      end
   end

   // Stage 5: partial products of r2*len2, cross^2, p^2, c*len2
   logic            v5_ff;
   mid_type         mid5_ff;
   logic [2*HB-1:0] pp5_ff [4][4];
   logic [2*HB-1:0] pp5_in [4][4];

   always_comb begin
      logic [SB-1:0] opa [4];
      logic [SB-1:0] opb [4];
      opa[0] = r24_ff;   opb[0] = mid4_ff.len2;
      opa[1] = magx4_ff; opb[1] = magx4_ff;
      opa[2] = magp4_ff; opb[2] = magp4_ff;
      opa[3] = cu4_ff;   opb[3] = mid4_ff.len2;
      for (int k = 0; k < 4; k++) begin
         pp5_in[k][0] = (2*HB)'(opa[k][HB-1:0]) * (2*HB)'(opb[k][HB-1:0]);
         pp5_in[k][1] = (2*HB)'(opa[k][HB-1:0]) * (2*HB)'(opb[k][SB-1:HB]);
         pp5_in[k][2] = (2*HB)'(opa[k][SB-1:HB]) * (2*HB)'(opb[k][HB-1:0]);
         pp5_in[k][3] = (2*HB)'(opa[k][SB-1:HB]) * (2*HB)'(opb[k][SB-1:HB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid5_ff <= mid4_ff;
         pp5_ff  <= pp5_in;
      end
   end

   // Stage 6: assemble wide products
   logic          v6_ff;
   mid_type       mid6_ff;
   logic [WB-1:0] prod6_ff [4];
   logic [WB-1:0] prod6_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod6_in[k] = (WB'(pp5_ff[k][3]) << (2*HB)) +
                       ((WB'(pp5_ff[k][1]) + WB'(pp5_ff[k][2])) << HB) +
                       WB'(pp5_ff[k][0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid6_ff  <= mid5_ff;
         prod6_ff <= prod6_in;
      end
   end

   // Stage 7: discriminant and root operand
   logic          v7_ff, dok7_ff, dok7_in;
   mid_type       mid7_ff;
   logic [WB-1:0] disc7_ff, disc7_in;
   logic [TW-1:0] x7_ff, x7_in;

   always_comb begin
      dok7_in  = prod6_ff[0] >= prod6_ff[1];
      disc7_in = dok7_in ? prod6_ff[0] - prod6_ff[1] : '0;
      x7_in    = TW'(prod6_ff[2]) + TW'(prod6_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mid7_ff  <= mid6_ff;
         dok7_ff  <= dok7_in;
         disc7_ff <= disc7_in;
         x7_ff    <= x7_in;
      end
   end

   // Stage 8: hits, crossing count, length case
   logic          v8_ff;
   carry_type     c8_ff, c8_in;
   logic [TW-1:0] x8_ff;

   always_comb begin
      geo_flags_type fl;
      logic          near, do_len;
      logic [1:0]    cnt;
      fl = mid7_ff.fl;
      if (fl.zl || fl.bnn) near = fl.q1np;
      else if (fl.nb_ge)   near = fl.q2np;
      else                 near = dok7_ff;

      priority if (fl.zl)               cnt = fl.q1z ? CNT_ONE : CNT_NONE;
      else if (fl.q1n && fl.q2n)        cnt = CNT_NONE;
      else if (fl.q1n != fl.q2n)        cnt = CNT_ONE;
      else if (!dok7_ff)                cnt = CNT_NONE;
      else if (!fl.bpos && fl.nb_le)    cnt = CNT_TWO;
      else if (fl.bpos && fl.q1z)       cnt = CNT_ONE;
      else if (fl.nb_gt && fl.q2z)      cnt = CNT_ONE;
      else                              cnt = CNT_NONE;

      c8_in.o.loose = !fl.box && near;
      priority if (fl.box)              c8_in.o.strict = 1'b0;
      else if (fl.q1n && fl.q2n)        c8_in.o.strict = 1'b0;
      else if (fl.q1n != fl.q2n)        c8_in.o.strict = 1'b1;
      else                              c8_in.o.strict = near;
      c8_in.o.count = cnt;

      do_len = c8_in.o.loose && !fl.zl;
      c8_in.p = mid7_ff.p;
      c8_in.use_root = do_len && (cnt == CNT_ONE) && fl.c_ok;
      // ratio operands: whole length uses divisor one, chord uses 4*disc over len2
      if (!do_len) begin
         c8_in.y0 = '0;
         c8_in.l  = SB'(1);
      end else if (cnt == CNT_NONE) begin
         c8_in.y0 = TW'(mid7_ff.len2);
         c8_in.l  = SB'(1);
      end else if (cnt == CNT_TWO) begin
         c8_in.y0 = TW'(disc7_ff) << 2;
         c8_in.l  = mid7_ff.len2;
      end else begin
         c8_in.y0 = '0;
         c8_in.l  = mid7_ff.len2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (adv) v8_ff <= v7_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c8_ff <= c8_in;
         x8_ff <= x7_ff;
      end
   end

   // Square root of p^2 + c*len2, one result bit per stage
   logic          rt_v_ff   [RN];
   logic [TW-1:0] rt_t_ff   [RN];
   logic [RN-1:0] rt_res_ff [RN];
   carry_type     rt_c_ff   [RN];

   for (genvar i = 0; i < RN; i++) begin : g_root
      localparam int Bit = RT - i;
      logic          v_src;
      logic [TW-1:0] t_src, delta, t_in;
      logic [RN-1:0] res_src, res_in;
      carry_type     c_src;

      if (i == 0) begin : g_first
         assign v_src   = v8_ff;
         assign t_src   = x8_ff;
         assign res_src = '0;
         assign c_src   = c8_ff;
      end else begin : g_next
         assign v_src   = rt_v_ff[i-1];
         assign t_src   = rt_t_ff[i-1];
         assign res_src = rt_res_ff[i-1];
         assign c_src   = rt_c_ff[i-1];
      end

      always_comb begin
         delta = (TW'(res_src) << (Bit + 1)) + (TW'(1) << (2 * Bit));
         if (delta <= t_src) begin
            t_in   = t_src - delta;
            res_in = res_src | (RN'(1) << Bit);
         end else begin
            t_in   = t_src;
            res_in = res_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) rt_v_ff[i] <= 1'b0;
         else if (adv) rt_v_ff[i] <= v_src;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rt_t_ff[i]   <= t_in;
            rt_res_ff[i] <= res_in;
            rt_c_ff[i]   <= c_src;
         end
      end
   end

   // R1: m = S - p, kept only when positive
   logic          ra_v_ff;
   logic [MU-1:0] ra_mu_ff, ra_mu_in;
   carry_type     ra_c_ff;

   always_comb begin
      logic signed [MU:0] m;
      m = signed'((MU+1)'(rt_res_ff[RN-1])) - (MU+1)'(rt_c_ff[RN-1].p);
      ra_mu_in = (m > 0) ? m[MU-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) ra_v_ff <= 1'b0;
      else if (adv) ra_v_ff <= rt_v_ff[RN-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ra_mu_ff <= ra_mu_in;
         ra_c_ff  <= rt_c_ff[RN-1];
      end
   end

   // R2: partial products of m^2
   logic            rb_v_ff;
   logic [2*MH-1:0] rb_ll_ff, rb_lh_ff, rb_hh_ff, rb_ll_in, rb_lh_in, rb_hh_in;
   carry_type       rb_c_ff;

   always_comb begin
      logic [2*MH-1:0] mw;
      mw = (2*MH)'(ra_mu_ff);
      rb_ll_in = (2*MH)'(mw[MH-1:0]) * (2*MH)'(mw[MH-1:0]);
      rb_lh_in = (2*MH)'(mw[MH-1:0]) * (2*MH)'(mw[2*MH-1:MH]);
      rb_hh_in = (2*MH)'(mw[2*MH-1:MH]) * (2*MH)'(mw[2*MH-1:MH]);
   end

   always_ff @(posedge clock) begin
      if (reset) rb_v_ff <= 1'b0;
      else if (adv) rb_v_ff <= ra_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rb_ll_ff <= rb_ll_in;
         rb_lh_ff <= rb_lh_in;
         rb_hh_ff <= rb_hh_in;
         rb_c_ff  <= ra_c_ff;
      end
   end

   // R3: ratio root operands
   logic             rc_v_ff;
   logic [TW-1:0]    rc_y_ff, rc_y_in;
   logic [SB-1:0]    rc_l_ff;
   result_flags_type rc_o_ff;

   always_comb begin
      logic [TW-1:0] msq;
      msq = (TW'(rb_hh_ff) << (2 * MH)) + (TW'(rb_lh_ff) << (MH + 1)) + TW'(rb_ll_ff);
      rc_y_in = rb_c_ff.use_root ? msq : rb_c_ff.y0;
   end

   always_ff @(posedge clock) begin
      if (reset) rc_v_ff <= 1'b0;
      else if (adv) rc_v_ff <= rb_v_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rc_y_ff <= rc_y_in;
         rc_l_ff <= rb_c_ff.l;
         rc_o_ff <= rb_c_ff.o;
      end
   end

   // Largest k with k*k*L <= y, one bit per stage; a = k*L kept alongside
   logic             qt_v_ff [KB];
   logic [TW-1:0]    qt_t_ff [KB];
   logic [AB-1:0]    qt_a_ff [KB];
   logic [KB-1:0]    qt_k_ff [KB];
   logic [SB-1:0]    qt_l_ff [KB];
   result_flags_type qt_o_ff [KB];

   for (genvar j = 0; j < KB; j++) begin : g_ratio
      localparam int Bit = CB - j;
      logic             v_src;
      logic [TW-1:0]    t_src, delta, t_in;
      logic [AB-1:0]    a_src, a_in;
      logic [KB-1:0]    k_src, k_in;
      logic [SB-1:0]    l_src;
      result_flags_type o_src;

      if (j == 0) begin : g_first
         assign v_src = rc_v_ff;
         assign t_src = rc_y_ff;
         assign a_src = '0;
         assign k_src = '0;
         assign l_src = rc_l_ff;
         assign o_src = rc_o_ff;
      end else begin : g_next
         assign v_src = qt_v_ff[j-1];
         assign t_src = qt_t_ff[j-1];
         assign a_src = qt_a_ff[j-1];
         assign k_src = qt_k_ff[j-1];
         assign l_src = qt_l_ff[j-1];
         assign o_src = qt_o_ff[j-1];
      end

      always_comb begin
         delta = (TW'(a_src) << (Bit + 1)) + (TW'(l_src) << (2 * Bit));
         if (delta <= t_src) begin
            t_in = t_src - delta;
            a_in = a_src + (AB'(l_src) << Bit);
            k_in = k_src | (KB'(1) << Bit);
         end else begin
            t_in = t_src;
            a_in = a_src;
            k_in = k_src;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) qt_v_ff[j] <= 1'b0;
         else if (adv) qt_v_ff[j] <= v_src;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            qt_t_ff[j] <= t_in;
            qt_a_ff[j] <= a_in;
            qt_k_ff[j] <= k_in;
            qt_l_ff[j] <= l_src;
            qt_o_ff[j] <= o_src;
         end
      end
   end

   // Response side: last stage is the output register
   assign adv                = !qt_v_ff[KB-1] || rsp_ready;
   assign rsp_valid          = qt_v_ff[KB-1];
   assign rsp_hit_loose      = qt_o_ff[KB-1].loose;
   assign rsp_hit_strict     = qt_o_ff[KB-1].strict;
   assign rsp_crossing_count = qt_o_ff[KB-1].count;
   assign rsp_inside_length  = qt_k_ff[KB-1];

endmodule
